>>> hw/rtl/hex_dump_byte_formatter_top_assert.svh
// Assertion macros shared by the formatter modules.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef HEX_DUMP_BYTE_FORMATTER_TOP_ASSERT_SVH
`define HEX_DUMP_BYTE_FORMATTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDBF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HDBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/hdbf_pkg.sv
`timescale 1ns / 1ps
package hdbf_pkg;

	// Configuration register indexes.
	localparam logic CFG_IDX_MODE = 1'b0;
	localparam logic CFG_IDX_BPL  = 1'b1;

	// Bit positions inside display_mode.
	localparam int MODE_COLOUR  = 0;
	localparam int MODE_TEXT    = 1;
	localparam int MODE_DECIMAL = 2;

	localparam logic [7:0] BPL_RESET = 8'd15;

	// Colour codes.
	localparam logic [1:0] COLOUR_DEFAULT = 2'd0;
	localparam logic [1:0] COLOUR_YELLOW  = 2'd1;
	localparam logic [1:0] COLOUR_WHITE   = 2'd2;

	// Characters.
	localparam logic [7:0] CH_ESC     = 8'd27;
	localparam logic [7:0] CH_LBRACK  = 8'd91;
	localparam logic [7:0] CH_THREE   = 8'd51;
	localparam logic [7:0] CH_M       = 8'd109;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NL      = 8'd10;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_SEVEN   = 8'd55;
	localparam logic [7:0] PRINT_LOW  = 8'd33;
	localparam logic [7:0] PRINT_HIGH = 8'd126;

	// Serializer steps: five escape characters, three body characters, newline.
	localparam logic [3:0] STEP_ESC0  = 4'd0;
	localparam logic [3:0] STEP_ESC1  = 4'd1;
	localparam logic [3:0] STEP_ESC2  = 4'd2;
	localparam logic [3:0] STEP_ESC3  = 4'd3;
	localparam logic [3:0] STEP_ESC4  = 4'd4;
	localparam logic [3:0] STEP_BODY0 = 4'd5;
	localparam logic [3:0] STEP_BODY1 = 4'd6;
	localparam logic [3:0] STEP_BODY2 = 4'd7;
	localparam logic [3:0] STEP_NL    = 4'd8;

	typedef struct packed {
		logic [2:0] display_mode;
		logic [7:0] bytes_per_line_minus_one;
	} hdbf_cfg_t;

	// One classified byte: everything the back end needs to print it.
	typedef struct packed {
		logic       esc;
		logic [1:0] colour;
		logic [7:0] body0;
		logic [7:0] body1;
		logic [7:0] body2;
		logic       nl;
	} hdbf_desc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 4'd10) begin
			hex_digit = CH_ZERO + {4'd0, v};
		end else begin
			hex_digit = CH_SEVEN + {4'd0, v};
		end
	endfunction

	function automatic logic [7:0] colour_digit(input logic [1:0] c);
		case (c)
			COLOUR_YELLOW: colour_digit = CH_THREE;
			COLOUR_WHITE:  colour_digit = CH_SEVEN;
			default:       colour_digit = CH_NINE;
		endcase
	endfunction

endpackage

>>> hw/rtl/hdbf_front.sv
`timescale 1ns / 1ps
module hdbf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  hdbf_pkg::hdbf_cfg_t cfg,
	input  logic                push,
	input  logic [7:0]          data_byte,
	input  logic                start_of_file,
	output hdbf_pkg::hdbf_desc_t desc
);
	import hdbf_pkg::*;

	logic [7:0]  column_countdown_q;
	logic [1:0]  current_colour_q;
	logic [7:0]  cd_eff;
	logic        as_text;
	logic [1:0]  want;
	logic [1:0]  hund;
	logic [6:0]  rem;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [3:0]  ones;

	// Decimal digits: hundreds by compare, tens by reciprocal multiply (x*205>>11).
	always_comb begin
		if (data_byte >= 8'd200) begin
			hund = 2'd2;
			rem  = 7'(data_byte - 8'd200);
		end else if (data_byte >= 8'd100) begin
			hund = 2'd1;
			rem  = 7'(data_byte - 8'd100);
		end else begin
			hund = 2'd0;
			rem  = data_byte[6:0];
		end
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = 4'(rem - (7'(tens) * 7'd10));
	end

	always_comb begin
		as_text = cfg.display_mode[MODE_TEXT] && (data_byte >= PRINT_LOW)
			&& (data_byte <= PRINT_HIGH);
		if (as_text) begin
			want = COLOUR_YELLOW;
		end else if (data_byte == 8'd0) begin
			want = COLOUR_WHITE;
		end else begin
			want = COLOUR_DEFAULT;
		end
		cd_eff = start_of_file ? cfg.bytes_per_line_minus_one : column_countdown_q;

		desc.esc    = cfg.display_mode[MODE_COLOUR] && (want != current_colour_q);
		desc.colour = want;
		desc.nl     = (cd_eff == 8'd0);
		if (as_text) begin
			desc.body0 = CH_SPACE;
			desc.body1 = data_byte;
			desc.body2 = CH_SPACE;
		end else if (cfg.display_mode[MODE_DECIMAL]) begin
			desc.body0 = (data_byte >= 8'd100) ? (CH_ZERO + {6'd0, hund}) : CH_SPACE;
			desc.body1 = (data_byte >= 8'd10) ? (CH_ZERO + {4'd0, tens}) : CH_SPACE;
			desc.body2 = CH_ZERO + {4'd0, ones};
		end else begin
			desc.body0 = hex_digit(data_byte[7:4]);
			desc.body1 = hex_digit(data_byte[3:0]);
			desc.body2 = CH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_countdown_q <= BPL_RESET;
			current_colour_q   <= COLOUR_DEFAULT;
		end else if (push) begin
			if (desc.nl) begin
				column_countdown_q <= cfg.bytes_per_line_minus_one;
			end else begin
				column_countdown_q <= cd_eff - 8'd1;
			end
			if (desc.esc) begin
				current_colour_q <= want;
			end
		end
	end

endmodule

>>> hw/rtl/hdbf_fifo.sv
`timescale 1ns / 1ps
module hdbf_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hdbf_pkg::hdbf_desc_t wr_desc,
	input  logic                 pop,
	output hdbf_pkg::hdbf_desc_t rd_desc,
	output logic                 not_empty,
	output logic                 not_full
);
	import hdbf_pkg::*;

	`include "hex_dump_byte_formatter_top_assert.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hdbf_desc_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign rd_desc   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`HDBF_ASSERT_SAME(a_no_overflow, push, not_full, "queue written while full")
	`HDBF_ASSERT_SAME(a_no_underflow, pop, not_empty, "queue read while empty")
	`HDBF_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

>>> hw/rtl/hdbf_back.sv
`timescale 1ns / 1ps
module hdbf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hdbf_pkg::hdbf_desc_t head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast
);
	import hdbf_pkg::*;

	`include "hex_dump_byte_formatter_top_assert.svh"

	hdbf_desc_t cur_q;
	logic       cur_valid_q;
	logic [3:0] step_q;
	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_last_q;
	logic       slot_free;
	logic       load_out;
	logic       is_last;
	logic [7:0] ch;

	assign slot_free = !m_valid_q || m_tready;
	assign load_out  = cur_valid_q && slot_free;
	assign is_last   = ((step_q == STEP_BODY2) && !cur_q.nl) || (step_q == STEP_NL);
	// Refill from the queue when idle, or in the same cycle the last character goes out.
	assign pop       = head_valid && (!cur_valid_q || (load_out && is_last));

	always_comb begin
		case (step_q)
			STEP_ESC0:  ch = CH_ESC;
			STEP_ESC1:  ch = CH_LBRACK;
			STEP_ESC2:  ch = CH_THREE;
			STEP_ESC3:  ch = colour_digit(cur_q.colour);
			STEP_ESC4:  ch = CH_M;
			STEP_BODY0: ch = cur_q.body0;
			STEP_BODY1: ch = cur_q.body1;
			STEP_BODY2: ch = cur_q.body2;
			STEP_NL:    ch = CH_NL;
			default:    ch = CH_NL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load_out) begin
			m_data_q <= ch;
			m_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= STEP_ESC0;
			m_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= head.esc ? STEP_ESC0 : STEP_BODY0;
			end else if (load_out && is_last) begin
				cur_valid_q <= 1'b0;
			end else if (load_out) begin
				step_q <= step_q + 4'd1;
			end
			if (slot_free) begin
				m_valid_q <= load_out;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	`HDBF_ASSERT_SAME(a_step_range, cur_valid_q, step_q <= STEP_NL, "step past newline")
	`HDBF_ASSERT_SAME(a_pop_needs_room, pop && cur_valid_q, load_out && is_last,
		"descriptor replaced before its last character")
	`HDBF_ASSERT_NEXT(a_done_clears, load_out && is_last && !pop, !cur_valid_q,
		"finished descriptor still marked busy")

endmodule

>>> hw/rtl/hex_dump_byte_formatter_top.sv
// Each byte yields 3 to 9 characters, one per cycle unless m_tready stalls the output:
// 3 + 5 with a colour escape + 1 with newline; the output serializer sets the sustained byte rate.
// A byte passes the descriptor queue, the current descriptor register and the output register.
// The classifier and the descriptor queue take input transfers every cycle while the queue has room.
// Reset (arst_n low, asynchronous) clears the queue and output and restores mode 0, 16 per line,
// the column countdown at 15 and the default colour.
`timescale 1ns / 1ps
module hex_dump_byte_formatter_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [0:0] s_tuser,  // [0] start_of_file
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] text_char
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);
	import hdbf_pkg::*;

	hdbf_cfg_t  cfg_q;
	hdbf_desc_t front_desc;
	hdbf_desc_t head_desc;
	logic       push;
	logic       pop;
	logic       q_not_empty;
	logic       q_not_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_mode             <= 3'd0;
			cfg_q.bytes_per_line_minus_one <= BPL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_MODE: cfg_q.display_mode             <= cfg_wdata[2:0];
				CFG_IDX_BPL:  cfg_q.bytes_per_line_minus_one <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	assign s_tready = q_not_full;
	assign push     = s_tvalid && q_not_full;

	hdbf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.data_byte     (s_tdata),
		.start_of_file (s_tuser[0]),
		.desc          (front_desc)
	);

	hdbf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_desc   (front_desc),
		.pop       (pop),
		.rd_desc   (head_desc),
		.not_empty (q_not_empty),
		.not_full  (q_not_full)
	);

	hdbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_desc),
		.head_valid (q_not_empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import hdbf_pkg::*;

	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam int HOLD_CYCLES = 250;
	localparam logic [2:0] MODE_COLOUR_TEXT = (3'd1 << MODE_COLOUR) | (3'd1 << MODE_TEXT);
	localparam logic [2:0] MODE_ALL = 3'b111;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} dump_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic [0:0] s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_IDX_MODE;
	logic [7:0] cfg_wdata = 8'd0;

	raw_byte_t  pending_bytes [$];
	dump_char_t expected_chars [$];
	raw_byte_t  in_flight;
	int         src_wait;
	int         snk_wait;
	bit         src_idle_en = 1'b1;
	bit         snk_idle_en = 1'b1;
	logic       hold_go = 1'b0;
	int         hold_left;
	int         mismatch_count = 0;
	int         char_index = 0;

	// Shadow of the formatter's registers and running state.
	logic [2:0] mode_reg = 3'd0;
	logic [7:0] bpl_reg = BPL_RESET;
	logic [7:0] column_left = BPL_RESET;
	logic [1:0] colour_now = COLOUR_DEFAULT;

	hex_dump_byte_formatter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_UPPER_A + 8'(v) - 8'd10;
	endfunction

	// Works out the characters one byte produces and queues them.
	task automatic predict_dump(input raw_byte_t item);
		logic [7:0] b;
		logic       as_text;
		logic [1:0] want;
		logic [7:0] digit;
		logic [7:0] body [3];
		logic [7:0] char_list [$];
		b = item.data_byte;
		as_text = mode_reg[MODE_TEXT] && b >= PRINT_LOW && b <= PRINT_HIGH;
		if (item.start_of_file) begin
			column_left = bpl_reg;
		end
		if (as_text) begin
			body[0] = CH_SPACE;
			body[1] = b;
			body[2] = CH_SPACE;
		end else if (mode_reg[MODE_DECIMAL]) begin
			body[2] = CH_ZERO + b % 8'd10;
			body[1] = (b >= 8'd10) ? CH_ZERO + (b / 8'd10) % 8'd10 : CH_SPACE;
			body[0] = (b >= 8'd100) ? CH_ZERO + b / 8'd100 : CH_SPACE;
		end else begin
			body[0] = nibble_char(b[7:4]);
			body[1] = nibble_char(b[3:0]);
			body[2] = CH_SPACE;
		end
		if (mode_reg[MODE_COLOUR]) begin
			want = as_text ? COLOUR_YELLOW : (b == 8'd0 ? COLOUR_WHITE : COLOUR_DEFAULT);
			if (want != colour_now) begin
				colour_now = want;
				case (want)
					COLOUR_YELLOW: digit = CH_THREE;
					COLOUR_WHITE:  digit = CH_SEVEN;
					default:       digit = CH_NINE;
				endcase
				char_list.push_back(CH_ESC);
				char_list.push_back(CH_LBRACK);
				char_list.push_back(CH_THREE);
				char_list.push_back(digit);
				char_list.push_back(CH_M);
			end
		end
		for (int i = 0; i < 3; i++) begin
			char_list.push_back(body[i]);
		end
		if (column_left != 8'd0) begin
			column_left = column_left - 8'd1;
		end else begin
			char_list.push_back(CH_NL);
			column_left = bpl_reg;
		end
		foreach (char_list[i]) begin
			expected_chars.push_back({char_list[i], i == char_list.size() - 1});
		end
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	// Byte driver: one transfer per item, then a random pause unless src_idle_en is clear.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tuser <= 1'b0;
			src_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_dump(in_flight);
				src_wait = src_idle_en ? $urandom_range(0, 18) : 0;
			end
			if (!s_tvalid || s_tready) begin
				if (src_wait > 0) begin
					src_wait--;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					in_flight = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= in_flight.data_byte;
					s_tuser <= in_flight.start_of_file;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, so the formatter backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Character monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		dump_char_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					flag_error($sformatf("unexpected char %02h last %0b", m_tdata, m_tlast));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.text_char || m_tlast !== want.last_char) begin
						flag_error($sformatf("char %0d: expected %02h last %0b, got %02h last %0b",
							char_index, want.text_char, want.last_char, m_tdata, m_tlast));
					end
				end
				char_index++;
				snk_wait = snk_idle_en ? $urandom_range(0, 18) : 0;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (snk_wait > 0) begin
				snk_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic sof);
		pending_bytes.push_back({b, sof});
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_IDX_MODE) begin
			mode_reg = val[2:0];
		end else begin
			bpl_reg = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_bytes.size() != 0 || s_tvalid || expected_chars.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly random bytes, with the text and decimal boundaries weighted in.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 9))
					0: return 8'd32;
					1: return 8'd33;
					2: return 8'd126;
					3: return 8'd127;
					4: return 8'd9;
					5: return 8'd10;
					6: return 8'd99;
					7: return 8'd100;
					8: return 8'd255;
					default: return 8'd0;
				endcase
			end
			1: return 8'd0;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [7:0] bpl_val;
		logic [2:0] mode_val;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: hex, no colour, sixteen per line.
		@(negedge clk);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hA5, 1'b0);
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'h09, 1'b0);
		wait_idle();

		// Colour and text, three per line: printable edges, white for zero.
		write_reg(CFG_IDX_MODE, {5'd0, MODE_COLOUR_TEXT});
		write_reg(CFG_IDX_BPL, 8'd2);
		@(negedge clk);
		queue_byte(8'd33, 1'b1);
		queue_byte(8'd126, 1'b0);
		queue_byte(8'd32, 1'b0);
		queue_byte(8'd127, 1'b0);
		queue_byte(8'd0, 1'b0);
		queue_byte(8'd0, 1'b0);
		queue_byte(8'd65, 1'b0);
		queue_byte(8'd200, 1'b0);
		queue_byte(8'd126, 1'b0);
		wait_idle();

		// All mode bits, a newline after every byte; decimal padding at 9 and 10 (99 and 100 print as text).
		write_reg(CFG_IDX_MODE, {5'b11111, MODE_ALL});
		write_reg(CFG_IDX_BPL, 8'd0);
		@(negedge clk);
		queue_byte(8'd0, 1'b0);
		queue_byte(8'd9, 1'b0);
		queue_byte(8'd10, 1'b1);
		queue_byte(8'd99, 1'b0);
		queue_byte(8'd100, 1'b0);
		queue_byte(8'd255, 1'b0);
		queue_byte(8'd65, 1'b0);
		queue_byte(8'd7, 1'b0);
		wait_idle();

		for (int phase = 0; phase < 12; phase++) begin
			mode_val = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
			case (phase % 5)
				0: bpl_val = 8'd0;
				1: bpl_val = 8'd255;
				2: bpl_val = 8'd1;
				3: bpl_val = 8'($urandom_range(2, 7));
				default: bpl_val = 8'($urandom_range(0, 255));
			endcase
			write_reg(CFG_IDX_MODE, {5'($urandom_range(0, 31)), mode_val});
			write_reg(CFG_IDX_BPL, bpl_val);
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en = ($urandom_range(0, 3) != 0);
			if (phase == 4 || phase == 9) begin
				src_idle_en = 1'b0;
			end
			@(negedge clk);
			for (int k = 0; k < 29; k++) begin
				queue_byte(pick_byte(), (k == 0 && phase % 3 == 0) || $urandom_range(0, 15) == 0);
			end
			if (phase == 4 || phase == 9) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
